>>> hdl/cbfl_pkg.sv
// Package: command codes, pulse record, controller-to-datapath command and sequence tables.
`timescale 1ns / 1ps
package cbfl_pkg;

    localparam int CMD_W     = 2;
    localparam int OPERAND_W = 16;
    localparam int BYTE_W    = 8;
    localparam int STEP_W    = 4;

    localparam logic [CMD_W-1:0] CMD_WRITE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_RESET = 2'd2;
    localparam logic [CMD_W-1:0] CMD_NONE  = 2'd3;

    localparam logic [BYTE_W-1:0] OP_STORE_IMM = 8'h36;
    localparam logic [BYTE_W-1:0] OP_INC_PTR   = 8'h23;
    localparam logic [BYTE_W-1:0] OP_LOAD_PTR  = 8'h21;
    localparam logic [BYTE_W-1:0] PULLUP       = 8'hFF;

    localparam logic [STEP_W-1:0] LAST_WRITE = 4'd15;
    localparam logic [STEP_W-1:0] LAST_LOAD  = 4'd9;
    localparam logic [STEP_W-1:0] LAST_RESET = 4'd7;

    typedef struct packed {
        logic              ram_enable;
        logic              bus_drive;
        logic [BYTE_W-1:0] bus_byte;
        logic              cpu_reset_n;
        logic              last;
    } t_pulse;

    typedef struct packed {
        logic              load_operand;
        logic              load_out;
        logic [CMD_W-1:0]  cmd;
        logic [STEP_W-1:0] step;
    } t_dp_cmd;

    function automatic logic [STEP_W-1:0] last_step(input logic [CMD_W-1:0] cmd);
        logic [STEP_W-1:0] s;
        case (cmd)
            CMD_WRITE: s = LAST_WRITE;
            CMD_LOAD:  s = LAST_LOAD;
            CMD_RESET: s = LAST_RESET;
            default:   s = '0;
        endcase
        return s;
    endfunction

    function automatic t_pulse pulse_at(input logic [CMD_W-1:0] cmd,
                                        input logic [STEP_W-1:0] step,
                                        input logic [OPERAND_W-1:0] operand);
        t_pulse            p;
        logic              drv;
        logic [BYTE_W-1:0] b;
        p.ram_enable  = 1'b1;
        p.cpu_reset_n = 1'b1;
        p.last        = (step == last_step(cmd));
        drv           = 1'b0;
        b             = PULLUP;
        case (cmd)
            CMD_WRITE: begin
                if ((step >= 4'd1 && step <= 4'd6) || step == 4'd11 || step == 4'd12) begin
                    p.ram_enable = 1'b0;
                end
                if (step == 4'd1 || step == 4'd2) begin
                    drv = 1'b1;
                    b   = OP_STORE_IMM;
                end else if (step == 4'd5 || step == 4'd6) begin
                    drv = 1'b1;
                    b   = operand[BYTE_W-1:0];
                end else if (step == 4'd11 || step == 4'd12) begin
                    drv = 1'b1;
                    b   = OP_INC_PTR;
                end
            end
            CMD_LOAD: begin
                if (step != 4'd0) begin
                    p.ram_enable = 1'b0;
                end
                if (step == 4'd1 || step == 4'd2) begin
                    drv = 1'b1;
                    b   = OP_LOAD_PTR;
                end else if (step >= 4'd5 && step <= 4'd7) begin
                    drv = 1'b1;
                    b   = operand[BYTE_W-1:0];
                end else if (step >= 4'd8) begin
                    drv = 1'b1;
                    b   = operand[OPERAND_W-1:BYTE_W];
                end
            end
            CMD_RESET: begin
                if (step <= 4'd5) begin
                    p.cpu_reset_n = 1'b0;
                end
            end
            default: begin
                p.last = 1'b0;
            end
        endcase
        p.bus_drive = drv;
        p.bus_byte  = b;
        return p;
    endfunction

endpackage

>>> hdl/cbfl_if.sv
// Interfaces: command channel and pulse channel, each with source and sink modports.
`timescale 1ns / 1ps
interface cbfl_cmd_if import cbfl_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CMD_W-1:0]     cmd;
    logic [OPERAND_W-1:0] operand;
    modport source (output valid, output cmd, output operand, input ready);
    modport sink (input valid, input cmd, input operand, output ready);
endinterface

interface cbfl_pulse_if import cbfl_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              ram_enable;
    logic              bus_drive;
    logic [BYTE_W-1:0] bus_byte;
    logic              cpu_reset_n;
    logic              last;
    modport source (output valid, output ram_enable, output bus_drive, output bus_byte,
                    output cpu_reset_n, output last, input ready);
    modport sink (input valid, input ram_enable, input bus_drive, input bus_byte,
                  input cpu_reset_n, input last, output ready);
endinterface

>>> hdl/cpu_bus_forcing_loader_unit.sv
// Top level: bus-forcing loader, controller plus datapath.
// Usage:
//   i_cmd   : command channel (valid/ready). cmd 0 writes operand[7:0] at the CPU
//             pointer and advances it, cmd 1 loads the pointer with operand, cmd 2
//             pulses CPU reset, cmd 3 is accepted and produces nothing.
//   o_pulse : one transfer per CPU clock pulse with the pin levels to hold
//             (ram_enable, bus_drive, bus_byte, cpu_reset_n); last marks the
//             final pulse of a command.
//   Write byte gives 16 transfers, load pointer 10, reset CPU 8.
//   The first pulse is registered after the command transfer has moved the
//   controller into its run state; pulses then follow one per cycle while
//   o_pulse.ready is high. The step counter walks one pulse per cycle and
//   the next command is taken once the last pulse is registered.
//   The output register holds its pulse while the receiver stalls; the step
//   counter waits with it.
//   Synchronous reset drops any pending pulse and returns to idle.
`timescale 1ns / 1ps
module cpu_bus_forcing_loader_unit import cbfl_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    cbfl_cmd_if.sink           i_cmd,
    cbfl_pulse_if.source       o_pulse
);
    t_dp_cmd dp_cmd;
    t_pulse  pulse;

    cbfl_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_cmd.valid),
        .i_in_cmd    (i_cmd.cmd),
        .o_in_ready  (i_cmd.ready),
        .i_out_ready (o_pulse.ready),
        .o_out_valid (o_pulse.valid),
        .o_dp_cmd    (dp_cmd)
    );

    cbfl_dp u_dp (
        .i_clk     (i_clk),
        .i_dp_cmd  (dp_cmd),
        .i_operand (i_cmd.operand),
        .o_pulse   (pulse)
    );

    assign o_pulse.ram_enable  = pulse.ram_enable;
    assign o_pulse.bus_drive   = pulse.bus_drive;
    assign o_pulse.bus_byte    = pulse.bus_byte;
    assign o_pulse.cpu_reset_n = pulse.cpu_reset_n;
    assign o_pulse.last        = pulse.last;
endmodule

>>> hdl/cbfl_dp.sv
// Datapath: operand register and registered pulse output.
`timescale 1ns / 1ps
module cbfl_dp import cbfl_pkg::*; (
    input  logic                 i_clk,
    input  t_dp_cmd              i_dp_cmd,
    input  logic [OPERAND_W-1:0] i_operand,
    output t_pulse               o_pulse
);
    logic [OPERAND_W-1:0] r_operand;
    t_pulse               r_pulse;

    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.load_operand) begin
            r_operand <= i_operand;
        end
        if (i_dp_cmd.load_out) begin
            r_pulse <= pulse_at(i_dp_cmd.cmd, i_dp_cmd.step, r_operand);
        end
    end

    assign o_pulse = r_pulse;
endmodule

>>> hdl/cbfl_ctrl.sv
// Controller: command acceptance, step sequencing and output valid.
`timescale 1ns / 1ps
module cbfl_ctrl import cbfl_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic [CMD_W-1:0] i_in_cmd,
    output logic             o_in_ready,
    input  logic             i_out_ready,
    output logic             o_out_valid,
    output t_dp_cmd          o_dp_cmd
);
    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    logic              r_state, n_state;
    logic [STEP_W-1:0] r_step, n_step;
    logic [CMD_W-1:0]  r_cmd, n_cmd;
    logic              r_out_valid, n_out_valid;
    logic              in_xfer, load_out;

    assign o_in_ready = (r_state == ST_IDLE);
    assign in_xfer    = i_in_valid && o_in_ready;
    assign load_out   = (r_state == ST_RUN) && (!r_out_valid || i_out_ready);

    always_comb begin
        n_state     = r_state;
        n_step      = r_step;
        n_cmd       = r_cmd;
        n_out_valid = r_out_valid && !i_out_ready;
        case (r_state)
            ST_IDLE: begin
                if (in_xfer && i_in_cmd != CMD_NONE) begin
                    n_state = ST_RUN;
                    n_cmd   = i_in_cmd;
                    n_step  = '0;
                end
            end
            ST_RUN: begin
                if (load_out) begin
                    n_out_valid = 1'b1;
                    if (r_step == last_step(r_cmd)) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_step = r_step + 1'b1;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_step      <= '0;
            r_cmd       <= CMD_WRITE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_cmd       <= n_cmd;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid           = r_out_valid;
    assign o_dp_cmd.load_operand = in_xfer;
    assign o_dp_cmd.load_out     = load_out;
    assign o_dp_cmd.cmd          = r_cmd;
    assign o_dp_cmd.step         = r_step;

`ifndef SYNTHESIS
    a_step_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_RUN |-> r_step <= last_step(r_cmd))
        else $error("step beyond sequence end");
    a_unused_cmd_dropped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer && i_in_cmd == CMD_NONE |=> r_state == ST_IDLE)
        else $error("unused command started a sequence");
    a_cmd_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer && i_in_cmd != CMD_NONE |=> r_state == ST_RUN && r_step == '0 && r_out_valid == $past(r_out_valid && !i_out_ready))
        else $error("command did not start at step zero");
    a_end_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load_out && r_step == last_step(r_cmd) |=> r_state == ST_IDLE && r_out_valid)
        else $error("sequence did not finish on last pulse");
`endif
endmodule
